FILE: rtl/aocb_pkg.sv
package aocb_pkg;

    localparam int CHANNEL_BITS    = 8;
    localparam int ALPHA_FRAC_BITS = 8;
    localparam int ALPHA_W         = ALPHA_FRAC_BITS + 1;
    localparam int LANES           = 3;
    // dividend after dropping the common 2^ALPHA_FRAC_BITS factor
    localparam int QUOT_NUM_W      = CHANNEL_BITS + ALPHA_FRAC_BITS + 1;
    localparam int FRONT_PROD_W    = CHANNEL_BITS + ALPHA_W;
    localparam int NUM_W           = CHANNEL_BITS + 2 * ALPHA_FRAC_BITS + 2;

    localparam logic [ALPHA_W-1:0]      ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC_BITS;
    localparam logic [CHANNEL_BITS-1:0] CHAN_MAX  = {CHANNEL_BITS{1'b1}};

    typedef struct packed {
        logic [ALPHA_W-1:0]      rem;
        logic [CHANNEL_BITS-1:0] low;
        logic [CHANNEL_BITS-1:0] quo;
        logic                    sat;
    } lane_t;

    typedef struct packed {
        lane_t [LANES-1:0]  lane;
        logic [ALPHA_W-1:0] den;
        logic               clear;
    } stage_t;

endpackage

FILE: rtl/aocb_prep.sv
module aocb_prep (
    input  logic                                                   clk,
    input  logic                                                   en,
    input  logic [aocb_pkg::LANES-1:0][aocb_pkg::CHANNEL_BITS-1:0] front_ch,
    input  logic [aocb_pkg::LANES-1:0][aocb_pkg::CHANNEL_BITS-1:0] back_ch,
    input  logic [aocb_pkg::ALPHA_W-1:0]                           front_a,
    input  logic [aocb_pkg::ALPHA_W-1:0]                           back_a,
    output aocb_pkg::stage_t                                       stage_out
);

    localparam int AW = aocb_pkg::ALPHA_W;
    localparam int CB = aocb_pkg::CHANNEL_BITS;
    localparam int AF = aocb_pkg::ALPHA_FRAC_BITS;
    localparam int NL = aocb_pkg::LANES;
    localparam int PW = aocb_pkg::FRONT_PROD_W;
    localparam int NW = aocb_pkg::NUM_W;
    localparam int QW = aocb_pkg::QUOT_NUM_W;

    // stage A: clamp alphas, combined alpha, first products
    logic [AW-1:0]            af;
    logic [AW-1:0]            ab;
    logic [2*AW-1:0]          clr_prod;
    logic [AW-1:0]            oa_next;
    logic [AW-1:0]            oa_a_reg;
    logic [AW-1:0]            inv_af_a_reg;
    logic [NL-1:0][PW-1:0]    fa_a_reg;
    logic [NL-1:0][PW-1:0]    ba_a_reg;

    // stage B: dividend
    logic [NL-1:0][NW-1:0]    num;
    logic [NL-1:0][QW-1:0]    n_b_reg;
    logic [AW-1:0]            oa_b_reg;

    aocb_pkg::stage_t         stage_next;
    aocb_pkg::stage_t         stage_reg;

    always_comb
    begin
        af       = (front_a > aocb_pkg::ALPHA_ONE) ? aocb_pkg::ALPHA_ONE : front_a;
        ab       = (back_a > aocb_pkg::ALPHA_ONE) ? aocb_pkg::ALPHA_ONE : back_a;
        clr_prod = (2*AW)'(aocb_pkg::ALPHA_ONE - af) * (2*AW)'(aocb_pkg::ALPHA_ONE - ab);
        oa_next  = aocb_pkg::ALPHA_ONE - AW'(clr_prod >> AF);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oa_a_reg     <= oa_next;
            inv_af_a_reg <= aocb_pkg::ALPHA_ONE - af;
            for (int l = 0; l < NL; l++)
            begin
                fa_a_reg[l] <= PW'(front_ch[l]) * PW'(af);
                ba_a_reg[l] <= PW'(back_ch[l]) * PW'(ab);
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            num[l] = (NW'(fa_a_reg[l]) << AF) + NW'(ba_a_reg[l]) * NW'(inv_af_a_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oa_b_reg <= oa_a_reg;
            for (int l = 0; l < NL; l++)
            begin
                n_b_reg[l] <= num[l][AF +: QW];
            end
        end
    end

    // stage C: overflow check on the high part, seed the divider chain
    always_comb
    begin
        stage_next.den   = oa_b_reg;
        stage_next.clear = (oa_b_reg == '0);
        for (int l = 0; l < NL; l++)
        begin
            stage_next.lane[l].rem = n_b_reg[l][QW-1:CB];
            stage_next.lane[l].low = n_b_reg[l][CB-1:0];
            stage_next.lane[l].quo = '0;
            stage_next.lane[l].sat = (n_b_reg[l][QW-1:CB] >= oa_b_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

FILE: rtl/aocb_div_cell.sv
module aocb_div_cell (
    input  logic             clk,
    input  logic             en,
    input  aocb_pkg::stage_t stage_in,
    output aocb_pkg::stage_t stage_out
);

    localparam int AW = aocb_pkg::ALPHA_W;
    localparam int CB = aocb_pkg::CHANNEL_BITS;

    aocb_pkg::stage_t               stage_next;
    aocb_pkg::stage_t               stage_reg;
    logic [aocb_pkg::LANES-1:0][AW-1:0] trial;
    logic [aocb_pkg::LANES-1:0]     ge;

    // one restoring step per lane: bring in the next dividend bit
    always_comb
    begin
        stage_next.den   = stage_in.den;
        stage_next.clear = stage_in.clear;
        for (int l = 0; l < aocb_pkg::LANES; l++)
        begin
            trial[l] = {stage_in.lane[l].rem[AW-2:0], stage_in.lane[l].low[CB-1]};
            ge[l]    = (trial[l] >= stage_in.den);
            stage_next.lane[l].rem = ge[l] ? (trial[l] - stage_in.den) : trial[l];
            stage_next.lane[l].low = {stage_in.lane[l].low[CB-2:0], 1'b0};
            stage_next.lane[l].quo = {stage_in.lane[l].quo[CB-2:0], ge[l]};
            stage_next.lane[l].sat = stage_in.lane[l].sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

FILE: rtl/alpha_over_color_blend_unit.sv
// Alpha over compositing, one color pair per transfer.
// Inputs pass through the prep stages A, B and C, then the chain of divider cells, to output valid.
// Throughput: one item per cycle; the whole pipeline holds while the output stalls.
// The divider is a chain of CHANNEL_BITS cells, one quotient bit per cell.
// Reset (rst_n, async, active low) clears only the stage valid bits.
module alpha_over_color_blend_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [aocb_pkg::CHANNEL_BITS-1:0]   front_red,
    input  logic [aocb_pkg::CHANNEL_BITS-1:0]   front_green,
    input  logic [aocb_pkg::CHANNEL_BITS-1:0]   front_blue,
    input  logic [aocb_pkg::ALPHA_W-1:0]        front_alpha,
    input  logic [aocb_pkg::CHANNEL_BITS-1:0]   back_red,
    input  logic [aocb_pkg::CHANNEL_BITS-1:0]   back_green,
    input  logic [aocb_pkg::CHANNEL_BITS-1:0]   back_blue,
    input  logic [aocb_pkg::ALPHA_W-1:0]        back_alpha,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [aocb_pkg::CHANNEL_BITS-1:0]   out_red,
    output logic [aocb_pkg::CHANNEL_BITS-1:0]   out_green,
    output logic [aocb_pkg::CHANNEL_BITS-1:0]   out_blue,
    output logic [aocb_pkg::ALPHA_W-1:0]        out_alpha,
    output logic                                fully_clear
);

    localparam int CB    = aocb_pkg::CHANNEL_BITS;
    localparam int DEPTH = 3 + CB;

    logic                                         adv;
    logic [DEPTH-1:0]                             vld_reg;
    logic [DEPTH-1:0]                             vld_next;
    logic [aocb_pkg::LANES-1:0][CB-1:0]           front_ch;
    logic [aocb_pkg::LANES-1:0][CB-1:0]           back_ch;
    aocb_pkg::stage_t                             chain [CB+1];
    logic [aocb_pkg::LANES-1:0][CB-1:0]           res_ch;

    assign adv      = !vld_reg[DEPTH-1] || out_ready;
    assign in_ready = adv;

    assign front_ch = {front_blue, front_green, front_red};
    assign back_ch  = {back_blue, back_green, back_red};

    assign vld_next = {vld_reg[DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    aocb_prep u_prep (
        .clk       (clk),
        .en        (adv),
        .front_ch  (front_ch),
        .back_ch   (back_ch),
        .front_a   (front_alpha),
        .back_a    (back_alpha),
        .stage_out (chain[0])
    );

    for (genvar i = 0; i < CB; i++)
    begin : g_cell
        aocb_div_cell u_cell (
            .clk       (clk),
            .en        (adv),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    always_comb
    begin
        for (int l = 0; l < aocb_pkg::LANES; l++)
        begin
            if (chain[CB].clear)
            begin
                res_ch[l] = '0;
            end
            else if (chain[CB].lane[l].sat)
            begin
                res_ch[l] = aocb_pkg::CHAN_MAX;
            end
            else
            begin
                res_ch[l] = chain[CB].lane[l].quo;
            end
        end
    end

    assign out_valid   = vld_reg[DEPTH-1];
    assign out_red     = res_ch[0];
    assign out_green   = res_ch[1];
    assign out_blue    = res_ch[2];
    assign out_alpha   = chain[CB].den;
    assign fully_clear = chain[CB].clear;

endmodule

FILE: sim/tb_alpha_over_color_blend_unit.sv
module tb_alpha_over_color_blend_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNEL_BITS    = aocb_pkg::CHANNEL_BITS;
    localparam int ALPHA_FRAC_BITS = aocb_pkg::ALPHA_FRAC_BITS;
    localparam int ALPHA_W         = aocb_pkg::ALPHA_W;

    localparam int RANDOM_PAIRS = 1750;
    localparam int QUIET_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_AFTER   = 400;
    localparam int TAIL_CYCLES  = 3 + CHANNEL_BITS + 8;

    typedef struct packed {
        logic                    quick;   // no idle gap after this one
        logic [CHANNEL_BITS-1:0] front_r;
        logic [CHANNEL_BITS-1:0] front_g;
        logic [CHANNEL_BITS-1:0] front_b;
        logic [ALPHA_W-1:0]      front_a;
        logic [CHANNEL_BITS-1:0] back_r;
        logic [CHANNEL_BITS-1:0] back_g;
        logic [CHANNEL_BITS-1:0] back_b;
        logic [ALPHA_W-1:0]      back_a;
    } color_pair_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
        logic [ALPHA_W-1:0]      alpha;
        logic                    clear;
    } blend_t;

    logic                    clk;
    logic                    rst_n       = 1'b0;
    logic                    in_valid    = 1'b0;
    logic                    in_ready;
    logic [CHANNEL_BITS-1:0] front_red   = '0;
    logic [CHANNEL_BITS-1:0] front_green = '0;
    logic [CHANNEL_BITS-1:0] front_blue  = '0;
    logic [ALPHA_W-1:0]      front_alpha = '0;
    logic [CHANNEL_BITS-1:0] back_red    = '0;
    logic [CHANNEL_BITS-1:0] back_green  = '0;
    logic [CHANNEL_BITS-1:0] back_blue   = '0;
    logic [ALPHA_W-1:0]      back_alpha  = '0;
    logic                    out_valid;
    logic                    out_ready   = 1'b0;
    logic [CHANNEL_BITS-1:0] out_red;
    logic [CHANNEL_BITS-1:0] out_green;
    logic [CHANNEL_BITS-1:0] out_blue;
    logic [ALPHA_W-1:0]      out_alpha;
    logic                    fully_clear;

    color_pair_t pending_pairs[$];
    blend_t      owed_blends[$];
    color_pair_t on_bus;
    int unsigned gap_left       = 0;
    int unsigned stall_left     = 0;
    int unsigned accepted_items = 0;
    int unsigned results_seen   = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned mismatch_count = 0;
    logic        hold_off       = 1'b0;
    logic        rx_eager       = 1'b0;

    alpha_over_color_blend_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .front_red   (front_red),
        .front_green (front_green),
        .front_blue  (front_blue),
        .front_alpha (front_alpha),
        .back_red    (back_red),
        .back_green  (back_green),
        .back_blue   (back_blue),
        .back_alpha  (back_alpha),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .out_alpha   (out_alpha),
        .fully_clear (fully_clear)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned clamp_alpha(logic [ALPHA_W-1:0] raw);
        longint unsigned unit;
        unit = longint'(1) << ALPHA_FRAC_BITS;
        return (raw > unit) ? unit : longint'(raw);
    endfunction

    function automatic logic [CHANNEL_BITS-1:0] mix_channel(
        longint unsigned cf, longint unsigned cb, longint unsigned af,
        longint unsigned ab, longint unsigned oa);
        longint unsigned unit;
        longint unsigned top;
        longint unsigned q;
        unit = longint'(1) << ALPHA_FRAC_BITS;
        top  = (longint'(1) << CHANNEL_BITS) - 1;
        if (oa == 0)
            return '0;
        q = (cf * af * unit + cb * ab * (unit - af)) / (oa * unit);
        return (q > top) ? CHANNEL_BITS'(top) : CHANNEL_BITS'(q);
    endfunction

    function automatic blend_t blend_over(color_pair_t p);
        longint unsigned unit;
        longint unsigned af;
        longint unsigned ab;
        longint unsigned oa;
        blend_t r;
        unit = longint'(1) << ALPHA_FRAC_BITS;
        af = clamp_alpha(p.front_a);
        ab = clamp_alpha(p.back_a);
        oa = unit - (((unit - af) * (unit - ab)) >> ALPHA_FRAC_BITS);
        r.red   = mix_channel(p.front_r, p.back_r, af, ab, oa);
        r.green = mix_channel(p.front_g, p.back_g, af, ab, oa);
        r.blue  = mix_channel(p.front_b, p.back_b, af, ab, oa);
        r.alpha = ALPHA_W'(oa);
        r.clear = (oa == 0);
        return r;
    endfunction

    task automatic note_mismatch(string what);
        mismatch_count++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    task automatic queue_pair(int fr, int fg, int fb, int fa, int br, int bg, int bb, int ba);
        color_pair_t p;
        p.quick   = $urandom_range(0, 1);
        p.front_r = CHANNEL_BITS'(fr);
        p.front_g = CHANNEL_BITS'(fg);
        p.front_b = CHANNEL_BITS'(fb);
        p.front_a = ALPHA_W'(fa);
        p.back_r  = CHANNEL_BITS'(br);
        p.back_g  = CHANNEL_BITS'(bg);
        p.back_b  = CHANNEL_BITS'(bb);
        p.back_a  = ALPHA_W'(ba);
        pending_pairs = {pending_pairs, p};
    endtask

    function automatic int pick_channel();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 0;
        if (sel == 1)
            return (1 << CHANNEL_BITS) - 1;
        return $urandom_range(0, (1 << CHANNEL_BITS) - 1);
    endfunction

    // mostly legal alphas, with a share above 1.0 that must saturate
    function automatic int pick_alpha();
        int unit;
        int sel;
        unit = 1 << ALPHA_FRAC_BITS;
        sel  = $urandom_range(0, 9);
        case (sel)
            6:       return 0;
            7:       return unit;
            8:       return $urandom_range(unit + 1, (1 << ALPHA_W) - 1);
            9:       return $urandom_range(0, 16);
            default: return $urandom_range(0, unit);
        endcase
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        color_pair_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                owed_blends = {owed_blends, blend_over(on_bus)};
                accepted_items <= accepted_items + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_pairs.size() != 0)
                begin
                    nxt = pending_pairs.pop_front();
                    on_bus = nxt;
                    front_red   <= nxt.front_r;
                    front_green <= nxt.front_g;
                    front_blue  <= nxt.front_b;
                    front_alpha <= nxt.front_a;
                    back_red    <= nxt.back_r;
                    back_green  <= nxt.back_g;
                    back_blue   <= nxt.back_b;
                    back_alpha  <= nxt.back_a;
                    in_valid    <= 1'b1;
                    gap_left    <= (nxt.quick || hold_off) ? 0 : $urandom_range(0, 19);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        blend_t got;
        blend_t want;
        int unsigned stall_n;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            stall_n = stall_left;
            if (out_valid && out_ready)
            begin
                got.red   = out_red;
                got.green = out_green;
                got.blue  = out_blue;
                got.alpha = out_alpha;
                got.clear = fully_clear;
                if (owed_blends.size() == 0)
                begin
                    note_mismatch("result transfer with nothing expected");
                end
                else
                begin
                    want = owed_blends.pop_front();
                    if (got.red !== want.red)
                        note_mismatch($sformatf("out_red %0d, want %0d", got.red, want.red));
                    if (got.green !== want.green)
                        note_mismatch($sformatf("out_green %0d, want %0d",
                                                got.green, want.green));
                    if (got.blue !== want.blue)
                        note_mismatch($sformatf("out_blue %0d, want %0d", got.blue, want.blue));
                    if (got.alpha !== want.alpha)
                        note_mismatch($sformatf("out_alpha %0d, want %0d",
                                                got.alpha, want.alpha));
                    if (got.clear !== want.clear)
                        note_mismatch($sformatf("fully_clear %0b, want %0b",
                                                got.clear, want.clear));
                end
                results_seen++;
                // switch between stalling and streaming stretches
                if (results_seen % 64 == 0)
                    rx_eager = ($urandom_range(0, 2) == 0);
                stall_n = rx_eager ? 0 : $urandom_range(0, 19);
            end
            if (hold_off)
            begin
                out_ready <= 1'b0;
            end
            else if (stall_n != 0)
            begin
                out_ready <= 1'b0;
                stall_n--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
            stall_left <= stall_n;
        end
    end

    // long output stall so the pipeline fills and backs up the input
    initial
    begin
        wait (accepted_items >= HOLD_AFTER);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready)))
            quiet_cycles <= quiet_cycles + 1;
        else
            quiet_cycles <= 0;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("tb_alpha_over_color_blend_unit: errors");
            $finish;
        end
    end

    initial
    begin
        int unit;
        unit = 1 << ALPHA_FRAC_BITS;

        // both alphas zero
        queue_pair(0, 0, 0, 0, 0, 0, 0, 0);
        queue_pair(255, 255, 255, 0, 255, 255, 255, 0);
        // opaque front hides back, transparent front shows back
        queue_pair(255, 255, 255, unit, 0, 0, 0, unit);
        queue_pair(0, 0, 0, unit, 255, 255, 255, unit);
        queue_pair(200, 100, 50, 0, 10, 20, 30, unit);
        queue_pair(12, 34, 56, 0, 78, 90, 123, 128);
        queue_pair(255, 255, 255, unit, 255, 255, 255, unit);
        // alpha above 1.0 saturates
        queue_pair(255, 0, 255, 511, 0, 255, 0, 511);
        queue_pair(17, 34, 51, unit + 1, 255, 255, 255, 0);
        queue_pair(255, 255, 255, 0, 1, 2, 3, 300);
        queue_pair(0, 0, 0, 384, 0, 0, 0, 511);
        queue_pair(85, 170, 85, 256, 170, 85, 170, 255);
        // floored alpha near the channel limit
        queue_pair(255, 255, 255, 128, 255, 255, 255, 128);
        queue_pair(255, 255, 255, 1, 255, 255, 255, 1);
        queue_pair(255, 255, 255, 255, 255, 255, 255, 255);
        queue_pair(0, 255, 0, 1, 255, 0, 255, 0);
        queue_pair(128, 64, 32, 64, 32, 64, 128, 192);
        queue_pair(255, 128, 1, 2, 254, 127, 0, 255);
        queue_pair(255, 255, 255, 1, 255, 255, 255, 0);

        for (int i = 0; i < RANDOM_PAIRS; i++)
            queue_pair(pick_channel(), pick_channel(), pick_channel(), pick_alpha(),
                       pick_channel(), pick_channel(), pick_channel(), pick_alpha());

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_pairs.size() != 0 || in_valid || owed_blends.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_alpha_over_color_blend_unit: clean");
        else
            $display("tb_alpha_over_color_blend_unit: errors");
        $finish;
    end

endmodule

FILE: files.f
rtl/aocb_pkg.sv
rtl/aocb_prep.sv
rtl/aocb_div_cell.sv
rtl/alpha_over_color_blend_unit.sv
sim/tb_alpha_over_color_blend_unit.sv
